### hw/rtl/xml_text_entity_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// XML text entity decoder: assertion macros
// Shared concurrent check forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef XML_TEXT_ENTITY_DECODER_UNIT_DEFINES_SVH
`define XML_TEXT_ENTITY_DECODER_UNIT_DEFINES_SVH

// Property holds at every edge outside reset.
`define XTED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define XTED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

### hw/rtl/xted_pkg.sv
// ----------------------------------------------------------------------------
// XML text entity decoder package
// Sizes, character codes and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package xted_pkg;

  localparam int WINDOW_BYTES = 8;
  localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);
  localparam int IDX_W        = $clog2(WINDOW_BYTES);
  localparam int CODE_W       = 21;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_NUM,
    ST_CODE,
    ST_RAW
  } state_t;

  typedef enum logic [1:0] {
    POP_NONE,
    POP_ONE,
    POP_PREFIX,
    POP_REF
  } pop_t;

  typedef enum logic [2:0] {
    PUT_NONE,
    PUT_HEAD,
    PUT_NAMED,
    PUT_BAD,
    PUT_CODE
  } put_t;

  typedef struct packed {
    logic load;
    pop_t pop;
    put_t put;
    logic cont_load;
    logic cont_dec;
    logic num_start;
    logic num_step;
    logic code_step;
    logic raw_start;
    logic raw_step;
    logic flush;
    logic eot;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic cont_busy;
    logic lead;
    logic amp;
    logic semi;
    logic full;
    logic len_ok;
    logic numeric;
    logic named;
    logic rem_one;
    logic num_bad;
    logic code_none;
    logic code_last;
    logic put_ok;
    logic flush_ok;
    logic hold_v;
  } stat_t;

endpackage

### hw/rtl/xted_ctrl.sv
// ----------------------------------------------------------------------------
// XML text entity decoder: controller
// Walks the pending window one action per cycle while the output does not stall it, and sequences references.
// ----------------------------------------------------------------------------
module xted_ctrl import xted_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tlast,
  output logic  s_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   eot;
  logic   finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eot   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && s_tvalid) begin
        eot <= s_tlast;
      end
    end
  end

  // nothing left to do for this item: empty window, or an '&' still waiting
  assign finish = st.empty ||
                  (st.amp && !st.cont_busy && !st.lead && !st.semi && !st.full && !eot);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.eot    = eot;
    s_tready   = (state == ST_IDLE) && !rst;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          if (!eot && !st.hold_v) begin
            state_next = ST_IDLE;
          end else if (st.flush_ok) begin
            cmd.flush  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (st.cont_busy || st.lead || !st.amp) begin
          if (st.put_ok) begin
            cmd.put       = PUT_HEAD;
            cmd.pop       = POP_ONE;
            cmd.cont_dec  = st.cont_busy;
            cmd.cont_load = !st.cont_busy && st.lead;
          end
        end else if (!st.semi || !st.len_ok) begin
          cmd.pop = POP_ONE;
        end else if (st.numeric) begin
          cmd.num_start = 1'b1;
          cmd.pop       = POP_PREFIX;
          state_next    = ST_NUM;
        end else if (st.named) begin
          if (st.put_ok) begin
            cmd.put = PUT_NAMED;
            cmd.pop = POP_REF;
          end
        end else begin
          cmd.raw_start = 1'b1;
          state_next    = ST_RAW;
        end
      end
      ST_NUM: begin
        if (!st.rem_one) begin
          cmd.num_step = 1'b1;
          cmd.pop      = POP_ONE;
        end else if (!st.num_bad) begin
          cmd.pop    = POP_ONE;
          state_next = ST_CODE;
        end else if (st.put_ok) begin
          cmd.pop    = POP_ONE;
          cmd.put    = PUT_BAD;
          state_next = ST_RUN;
        end
      end
      ST_CODE: begin
        if (st.code_none) begin
          state_next = ST_RUN;
        end else if (st.put_ok) begin
          cmd.put       = PUT_CODE;
          cmd.code_step = 1'b1;
          if (st.code_last) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RAW: begin
        if (st.put_ok) begin
          cmd.put      = PUT_HEAD;
          cmd.pop      = POP_ONE;
          cmd.raw_step = 1'b1;
          if (st.rem_one) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/xted_datapath.sv
// ----------------------------------------------------------------------------
// XML text entity decoder: datapath
// Pending window, reference scan, numeric accumulator, UTF-8 encoder and the
// hold/output registers that mark the last result of each item.
// ----------------------------------------------------------------------------
`include "xml_text_entity_decoder_unit_defines.svh"

module xted_datapath import xted_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       utf8_mode,
  input  logic [3:0] min_entity_len,
  input  logic [7:0] in_byte,
  input  cmd_t       cmd,
  output stat_t      st,
  input  logic       m_tready,
  output logic       m_tvalid,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [2:0] m_tuser
);

  localparam int NAME_CMP = (WINDOW_BYTES < 6) ? WINDOW_BYTES : 6;
  localparam logic [7:0] NAME_TXT [5][6] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
  };
  localparam logic [3:0] NAME_LEN [5] = '{4'd5, 4'd4, 4'd4, 4'd6, 4'd6};
  localparam logic [7:0] NAME_CHR [5] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  logic [7:0]       pend [WINDOW_BYTES];
  logic [7:0]       pend_sh [WINDOW_BYTES];
  logic [CNT_W-1:0] count;
  logic [1:0]       cont;
  logic [CNT_W-1:0] rem;
  logic             is_hex, got_digit, bad_digit, stop;
  logic [CODE_W-1:0] code;
  logic             big;
  logic [1:0]       idx;

  logic             hold_v, hold_bv, hold_bad;
  logic [7:0]       hold_byte;
  logic             out_v, out_bv, out_last, out_done, out_bad;
  logic [7:0]       out_byte;

  logic [7:0]       head;
  logic             semi;
  logic [CNT_W-1:0] semi_pos, ref_len, pop_n;
  logic [1:0]       lead_amt;
  logic             numeric, hex_ref, named;
  logic [7:0]       named_chr;
  logic             dec_ok, hex_ok;
  logic [3:0]       dig_val, hex_val;
  logic [CODE_W+3:0] acc_dec, acc_hex;
  logic [2:0]       code_n, pos;
  logic [CODE_W-1:0] code_sh;
  logic [7:0]       code_byte;
  logic [7:0]       put_byte;
  logic             put_bv, put_bad, put_active;
  logic             put_ok, flush_ok;

  assign head = pend[0];

  // first ';' after the head among the held bytes
  always_comb begin
    semi     = 1'b0;
    semi_pos = '0;
    for (int i = WINDOW_BYTES - 1; i >= 1; i--) begin
      if (CNT_W'(i) < count && pend[i] == CH_SEMI) begin
        semi     = 1'b1;
        semi_pos = CNT_W'(i);
      end
    end
  end
  assign ref_len = semi_pos + CNT_W'(1);

  always_comb begin
    if (head >= 8'hC2 && head <= 8'hDF) begin
      lead_amt = 2'd1;
    end else if (head >= 8'hE0 && head <= 8'hEF) begin
      lead_amt = 2'd2;
    end else if (head >= 8'hF0 && head <= 8'hF4) begin
      lead_amt = 2'd3;
    end else begin
      lead_amt = 2'd0;
    end
  end

  assign numeric = (int'(ref_len) >= 3) && (pend[1] == CH_HASH);
  assign hex_ref = numeric && (int'(ref_len) >= 4) && (pend[2] == CH_X);

  always_comb begin
    logic eq;
    named     = 1'b0;
    named_chr = 8'h00;
    for (int k = 0; k < 5; k++) begin
      eq = (int'(ref_len) == int'(NAME_LEN[k]));
      for (int j = 0; j < NAME_CMP; j++) begin
        if (j < int'(NAME_LEN[k]) && pend[j] != NAME_TXT[k][j]) begin
          eq = 1'b0;
        end
      end
      if (eq && !named) begin
        named     = 1'b1;
        named_chr = NAME_CHR[k];
      end
    end
  end

  // digit decode of the head byte
  always_comb begin
    dec_ok  = (head >= 8'h30 && head <= 8'h39);
    dig_val = head[3:0];
    hex_ok  = 1'b1;
    if (head >= 8'h30 && head <= 8'h39) begin
      hex_val = head[3:0];
    end else if ((head >= 8'h61 && head <= 8'h66) || (head >= 8'h41 && head <= 8'h46)) begin
      hex_val = head[3:0] + 4'd9;
    end else begin
      hex_ok  = 1'b0;
      hex_val = 4'd0;
    end
  end

  assign acc_dec = {1'b0, code, 3'b000} + {3'b000, code, 1'b0} +
                   {{CODE_W{1'b0}}, dig_val};
  assign acc_hex = {code, hex_val};

  // UTF-8 length of the accumulated code point (one byte when utf8_mode is off); zero when it overflows 21 bits
  always_comb begin
    if (!utf8_mode) begin
      code_n = 3'd1;
    end else if (big) begin
      code_n = 3'd0;
    end else if (code < CODE_W'('h80)) begin
      code_n = 3'd1;
    end else if (code < CODE_W'('h800)) begin
      code_n = 3'd2;
    end else if (code < CODE_W'('h10000)) begin
      code_n = 3'd3;
    end else begin
      code_n = 3'd4;
    end
  end

  assign pos = code_n - 3'd1 - {1'b0, idx};

  always_comb begin
    case (pos[1:0])
      2'd0:    code_sh = code;
      2'd1:    code_sh = code >> 6;
      2'd2:    code_sh = code >> 12;
      2'd3:    code_sh = code >> 18;
      default: code_sh = code;
    endcase
    if (code_n == 3'd1) begin
      code_byte = code[7:0];
    end else if (idx == 2'd0) begin
      case (code_n)
        3'd2:    code_byte = 8'hC0 | code_sh[7:0];
        3'd3:    code_byte = 8'hE0 | code_sh[7:0];
        default: code_byte = 8'hF0 | code_sh[7:0];
      endcase
    end else begin
      code_byte = {2'b10, code_sh[5:0]};
    end
  end

  always_comb begin
    case (cmd.pop)
      POP_NONE:   pop_n = '0;
      POP_ONE:    pop_n = CNT_W'(1);
      POP_PREFIX: pop_n = hex_ref ? CNT_W'(3) : CNT_W'(2);
      POP_REF:    pop_n = ref_len;
      default:    pop_n = '0;
    endcase
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (i + int'(pop_n) < WINDOW_BYTES) begin
        pend_sh[i] = pend[IDX_W'(i + int'(pop_n))];
      end else begin
        pend_sh[i] = pend[i];
      end
    end
  end

  always_comb begin
    put_byte = 8'h00;
    put_bv   = 1'b1;
    put_bad  = 1'b0;
    case (cmd.put)
      PUT_NONE:  put_bv = 1'b0;
      PUT_HEAD:  put_byte = head;
      PUT_NAMED: put_byte = named_chr;
      PUT_BAD: begin
        put_bv  = 1'b0;
        put_bad = 1'b1;
      end
      PUT_CODE:  put_byte = code_byte;
      default:   put_bv = 1'b0;
    endcase
  end

  assign put_active = (cmd.put != PUT_NONE);
  assign put_ok     = !hold_v || !out_v || m_tready;
  assign flush_ok   = !out_v || m_tready;

  // pending window
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      if (count < CNT_W'(WINDOW_BYTES)) begin
        count <= count + CNT_W'(1);
      end
    end else if (cmd.flush && cmd.eot) begin
      count <= '0;
    end else if (cmd.pop != POP_NONE) begin
      count <= (pop_n >= count) ? '0 : count - pop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (count < CNT_W'(WINDOW_BYTES)) begin
        pend[count[IDX_W-1:0]] <= in_byte;
      end
    end else if (cmd.pop != POP_NONE) begin
      pend <= pend_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cont <= 2'd0;
    end else if (cmd.flush && cmd.eot) begin
      cont <= 2'd0;
    end else if (cmd.cont_load) begin
      cont <= lead_amt;
    end else if (cmd.cont_dec) begin
      cont <= cont - 2'd1;
    end
  end

  // reference sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.num_start) begin
      rem       <= ref_len - (hex_ref ? CNT_W'(3) : CNT_W'(2));
      is_hex    <= hex_ref;
      got_digit <= 1'b0;
      bad_digit <= 1'b0;
      stop      <= 1'b0;
      code      <= '0;
      big       <= 1'b0;
      idx       <= 2'd0;
    end else if (cmd.num_step) begin
      rem <= rem - CNT_W'(1);
      if (!is_hex) begin
        if (dec_ok) begin
          code      <= acc_dec[CODE_W-1:0];
          big       <= big | (|acc_dec[CODE_W+3:CODE_W]);
          got_digit <= 1'b1;
        end else begin
          bad_digit <= 1'b1;
        end
      end else if (!stop) begin
        if (hex_ok) begin
          code      <= acc_hex[CODE_W-1:0];
          big       <= big | (|acc_hex[CODE_W+3:CODE_W]);
          got_digit <= 1'b1;
        end else begin
          stop <= 1'b1;
        end
      end
    end else if (cmd.raw_start) begin
      rem <= ref_len;
    end else if (cmd.raw_step) begin
      rem <= rem - CNT_W'(1);
    end else if (cmd.code_step) begin
      idx <= idx + 2'd1;
    end
  end

  // one-deep hold so the last result of an item can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (put_active) begin
        hold_v <= 1'b1;
      end else if (cmd.flush) begin
        hold_v <= 1'b0;
      end
      if ((put_active && hold_v) || cmd.flush) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_active) begin
      hold_byte <= put_byte;
      hold_bv   <= put_bv;
      hold_bad  <= put_bad;
      if (hold_v) begin
        out_byte <= hold_byte;
        out_bv   <= hold_bv;
        out_bad  <= hold_bad;
        out_last <= 1'b0;
        out_done <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_last <= 1'b1;
      out_done <= cmd.eot;
      if (hold_v) begin
        out_byte <= hold_byte;
        out_bv   <= hold_bv;
        out_bad  <= hold_bad;
      end else begin
        out_byte <= 8'h00;
        out_bv   <= 1'b0;
        out_bad  <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_bad, out_done, out_bv};

  always_comb begin
    st           = '0;
    st.empty     = (count == '0);
    st.cont_busy = (cont != 2'd0);
    st.lead      = utf8_mode && (lead_amt != 2'd0);
    st.amp       = (head == CH_AMP);
    st.semi      = semi;
    st.full      = (count >= CNT_W'(WINDOW_BYTES));
    st.len_ok    = int'(ref_len) >= int'(min_entity_len);
    st.numeric   = numeric;
    st.named     = named;
    st.rem_one   = (rem == CNT_W'(1));
    st.num_bad   = bad_digit || !got_digit;
    st.code_none = (code_n == 3'd0);
    st.code_last = ({1'b0, idx} == code_n - 3'd1);
    st.put_ok    = put_ok;
    st.flush_ok  = flush_ok;
    st.hold_v    = hold_v;
  end

  `XTED_ASSERT(a_put_room, (put_active && hold_v) |-> (!out_v || m_tready), "hold spill")
  `XTED_ASSERT(a_count_range, count <= CNT_W'(WINDOW_BYTES), "pending count past window")
  `XTED_ASSERT(a_done_last, (out_v && out_done) |-> out_last, "text end without item end")
  `XTED_ASSERT_NEXT(a_flush_out, cmd.flush, (out_v && out_last), "flush without last result")

endmodule

### hw/rtl/xml_text_entity_decoder_unit.sv
// ----------------------------------------------------------------------------
// XML text entity decoder unit
// Decodes XML character text byte by byte: named and numeric references,
// UTF-8 lead/continuation pass-through, raw pass of unknown references.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = end_of_text
//   m_*       out  m_tvalid/m_tready  m_tdata = out_byte, m_tlast = run_last,
//                                     m_tuser = byte_valid, text_done, bad_reference
//   apb       in   psel/penable       0x0 utf8_mode, 0x4 min_entity_len
//
// An item is handled as an accept step, a step for each window byte handled
// (plain, lead, continuation, dropped '&', whole named reference), a start
// step and a step for each byte of a raw reference, for a numeric reference
// a step to strip the prefix, a step for each remaining byte and a step for
// each encoded byte (an empty step if nothing encodes, none if malformed),
// and a closing step, in the single controller sequence over the window.
// Reset is synchronous; the window starts empty with no continuation open.
// Results stall in a one-deep hold plus the output register when m_tready
// is low; a new item is taken while the last result still waits.
// ----------------------------------------------------------------------------
module xml_text_entity_decoder_unit import xted_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [2:0]  m_tuser,   // [0] byte_valid, [1] text_done, [2] bad_reference
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       utf8_mode;
  logic [3:0] min_entity_len;
  cmd_t       cmd;
  stat_t      st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_mode      <= 1'b1;
      min_entity_len <= 4'd3;
    end else if (psel && penable && pwrite) begin
      if (!paddr[2]) begin
        utf8_mode <= pwdata[0];
      end else begin
        min_entity_len <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'd0, min_entity_len} : {31'd0, utf8_mode};

  xted_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  xted_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .utf8_mode      (utf8_mode),
    .min_entity_len (min_entity_len),
    .in_byte        (s_tdata),
    .cmd            (cmd),
    .st             (st),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser)
  );

endmodule
